>>> rtl/core/gbfr_pkg.sv
// Shared types and constants for the binary navigation frame receiver.
// Holds the one-hot parse phase type, register indexes and the result record.
// No dependencies.
package gbfr_pkg;

	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CLASS_ACCEPT = 2'd2;

	localparam logic [7:0] SYNC_FIRST_RST   = 8'd181;
	localparam logic [7:0] SYNC_SECOND_RST  = 8'd98;
	localparam logic [7:0] CLASS_ACCEPT_RST = 8'd1;

	typedef enum logic [8:0] {
		PH_SYNC1  = 9'b000000001,
		PH_SYNC2  = 9'b000000010,
		PH_CLASS  = 9'b000000100,
		PH_ID     = 9'b000001000,
		PH_LEN_LO = 9'b000010000,
		PH_LEN_HI = 9'b000100000,
		PH_PAYLD  = 9'b001000000,
		PH_CK_A   = 9'b010000000,
		PH_CK_B   = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic        end_of_frame;
		logic [7:0]  message_id;
		logic [7:0]  byte_value;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic        frame_ok;
	} result_t;

endpackage

>>> rtl/core/gnss_binary_frame_receiver.sv
// Top level of the binary navigation frame receiver.
// Parses sync, class, id, length, payload and Fletcher-8 checksum byte by byte.
// Depends on gbfr_pkg.

// One received byte is taken per request and the receiver sustains one byte per clock
// while in_stall is low: the parse phase, counters and running checksum update in the
// cycle the byte is accepted, and any result is registered on that same clock edge.
// A second skid register lets input keep flowing for one more result while the
// output is stalled; in_stall rises only when both output registers hold results. Each
// payload byte yields one result with its index, the second checksum byte yields
// the frame end result with id, length and checksum verdict, and every other byte
// yields nothing. Configuration writes (sync bytes and accepted class) are meant to
// happen while the receiver is idle.
module gnss_binary_frame_receiver
	import gbfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               end_of_frame,
	output logic [7:0]         message_id,
	output logic [7:0]         byte_value,
	output logic [15:0]        byte_index,
	output logic [15:0]        frame_length,
	output logic               frame_ok
);

	logic [7:0] sync_first_q, sync_second_q, class_accept_q;

	phase_t      phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  ck_a_q, ck_a_d;

	logic [7:0]  add_a;
	logic [15:0] pos_inc;
	logic        in_acc;
	logic        res_vld;
	result_t     res;

	logic        out_vld_q, skid_vld_q;
	result_t     out_q, skid_q;
	logic        out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q   <= SYNC_FIRST_RST;
			sync_second_q  <= SYNC_SECOND_RST;
			class_accept_q <= CLASS_ACCEPT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SYNC_FIRST:   sync_first_q   <= cfg_wdata;
				REG_SYNC_SECOND:  sync_second_q  <= cfg_wdata;
				REG_CLASS_ACCEPT: class_accept_q <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	assign in_acc  = in_valid && !in_stall;
	assign add_a   = sum_a_q + rx_byte;
	assign pos_inc = pos_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		id_d    = id_q;
		ck_a_d  = ck_a_q;
		res_vld = 1'b0;
		res     = '0;
		res.message_id   = id_q;
		res.frame_length = len_q;
		case (phase_q)
			PH_SYNC1: begin
				if (rx_byte == sync_first_q) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == sync_second_q) ? PH_CLASS : PH_SYNC1;
			end
			PH_CLASS: begin
				// The class byte restarts the checksum from zero.
				if (rx_byte == class_accept_q) begin
					sum_a_d = rx_byte;
					sum_b_d = rx_byte;
					phase_d = PH_ID;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_ID: begin
				id_d    = rx_byte;
				sum_a_d = add_a;
				sum_b_d = sum_b_q + add_a;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d   = {8'd0, rx_byte};
				sum_a_d = add_a;
				sum_b_d = sum_b_q + add_a;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d   = {rx_byte, len_q[7:0]};
				sum_a_d = add_a;
				sum_b_d = sum_b_q + add_a;
				pos_d   = '0;
				// An empty payload goes straight to the checksum bytes.
				phase_d = ({rx_byte, len_q[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLD;
			end
			PH_PAYLD: begin
				sum_a_d        = add_a;
				sum_b_d        = sum_b_q + add_a;
				res_vld        = 1'b1;
				res.byte_value = rx_byte;
				res.byte_index = pos_q;
				pos_d          = pos_inc;
				if (pos_inc == len_q) phase_d = PH_CK_A;
			end
			PH_CK_A: begin
				ck_a_d  = rx_byte;
				phase_d = PH_CK_B;
			end
			PH_CK_B: begin
				res_vld          = 1'b1;
				res.end_of_frame = 1'b1;
				res.frame_ok     = (ck_a_q == sum_a_q) && (rx_byte == sum_b_q);
				phase_d          = PH_SYNC1;
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			pos_q   <= '0;
			len_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			id_q    <= '0;
			ck_a_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			id_q    <= id_d;
			ck_a_q  <= ck_a_d;
		end
	end

	// Output register plus one skid entry; input stalls only when the skid is full.
	assign out_take = out_vld_q && !out_stall;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_take) skid_vld_q <= 1'b0;
		end else if (in_acc && res_vld) begin
			if (!out_vld_q || out_take) out_vld_q <= 1'b1;
			else                        skid_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) out_q <= skid_q;
		end else if (in_acc && res_vld) begin
			if (!out_vld_q || out_take) out_q  <= res;
			else                        skid_q <= res;
		end
	end

	assign out_valid    = out_vld_q;
	assign end_of_frame = out_q.end_of_frame;
	assign message_id   = out_q.message_id;
	assign byte_value   = out_q.byte_value;
	assign byte_index   = out_q.byte_index;
	assign frame_length = out_q.frame_length;
	assign frame_ok     = out_q.frame_ok;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry holds a result while the output register is empty");

	a_ckb_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_CK_B) |=> out_vld_q)
		else $error("second checksum byte produced no end result");

	a_payload_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_q.end_of_frame) |->
			(out_q.byte_index < out_q.frame_length && !out_q.frame_ok))
		else $error("payload result index outside frame length");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.end_of_frame) |->
			(out_q.byte_value == 8'd0 && out_q.byte_index == 16'd0))
		else $error("end result carries payload byte fields");

endmodule

>>> dv/frame_checker.sv
// Checker for the binary navigation frame receiver: follows register writes and both
// channels, predicts every payload and frame end result and compares them in order.
// Depends on gbfr_pkg.
module frame_checker
	import gbfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               end_of_frame,
	input  logic [7:0]         message_id,
	input  logic [7:0]         byte_value,
	input  logic [15:0]        byte_index,
	input  logic [15:0]        frame_length,
	input  logic               frame_ok,
	output int unsigned        fail_count,
	output int unsigned        items_due
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  sync1_r, sync2_r, class_r;
	phase_t      parse_phase;
	logic [15:0] bytes_left, pay_pos, len_field;
	logic [7:0]  run_a, run_b, id_seen, ck_a_rx;
	result_t     frame_items_due[$];

	task automatic fold_sum(input logic [7:0] b);
		run_a = run_a + b;
		run_b = run_b + run_a;
	endtask

	task automatic advance_parser(input logic [7:0] b);
		result_t r;
		case (parse_phase)
			PH_SYNC1: if (b == sync1_r) parse_phase = PH_SYNC2;
			PH_SYNC2: parse_phase = (b == sync2_r) ? PH_CLASS : PH_SYNC1;
			PH_CLASS: begin
				if (b == class_r) begin
					run_a = 8'h00;
					run_b = 8'h00;
					fold_sum(b);
					parse_phase = PH_ID;
				end else begin
					parse_phase = PH_SYNC1;
				end
			end
			PH_ID: begin
				id_seen = b;
				fold_sum(b);
				parse_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_field = {8'h00, b};
				fold_sum(b);
				parse_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_field[15:8] = b;
				fold_sum(b);
				bytes_left = len_field;
				pay_pos = 16'h0000;
				// An empty payload skips straight to the checksum bytes.
				parse_phase = (len_field == 16'h0000) ? PH_CK_A : PH_PAYLD;
			end
			PH_PAYLD: begin
				fold_sum(b);
				r = '{end_of_frame: 1'b0, message_id: id_seen, byte_value: b,
					byte_index: pay_pos, frame_length: len_field, frame_ok: 1'b0};
				frame_items_due.push_back(r);
				pay_pos = pay_pos + 16'd1;
				bytes_left = bytes_left - 16'd1;
				if (bytes_left == 16'h0000) parse_phase = PH_CK_A;
			end
			PH_CK_A: begin
				ck_a_rx = b;
				parse_phase = PH_CK_B;
			end
			PH_CK_B: begin
				r = '{end_of_frame: 1'b1, message_id: id_seen, byte_value: 8'h00,
					byte_index: 16'h0000, frame_length: len_field,
					frame_ok: (ck_a_rx == run_a) && (b == run_b)};
				frame_items_due.push_back(r);
				parse_phase = PH_SYNC1;
			end
			default: parse_phase = PH_SYNC1;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sync1_r = SYNC_FIRST_RST;
			sync2_r = SYNC_SECOND_RST;
			class_r = CLASS_ACCEPT_RST;
			parse_phase = PH_SYNC1;
			bytes_left = 16'h0000;
			pay_pos = 16'h0000;
			len_field = 16'h0000;
			run_a = 8'h00;
			run_b = 8'h00;
			id_seen = 8'h00;
			ck_a_rx = 8'h00;
			frame_items_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SYNC_FIRST:   sync1_r = cfg_wdata;
					REG_SYNC_SECOND:  sync2_r = cfg_wdata;
					REG_CLASS_ACCEPT: class_r = cfg_wdata;
					default: ;
				endcase
			end
			// A result is registered in the receiver before it leaves, so it is
			// compared before the byte accepted on this edge is predicted.
			if (out_valid && !out_stall) begin
				if (frame_items_due.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual eof=%0d id=%0d",
						$time, end_of_frame, message_id);
					fail_count++;
				end else begin
					want = frame_items_due.pop_front();
					check_field("end_of_frame", 16'(want.end_of_frame), 16'(end_of_frame));
					check_field("message_id", 16'(want.message_id), 16'(message_id));
					check_field("byte_value", 16'(want.byte_value), 16'(byte_value));
					check_field("byte_index", want.byte_index, byte_index);
					check_field("frame_length", want.frame_length, frame_length);
					check_field("frame_ok", 16'(want.frame_ok), 16'(frame_ok));
				end
			end
			if (in_valid && !in_stall) advance_parser(rx_byte);
		end
		items_due = frame_items_due.size();
	end

endmodule

>>> dv/tb.sv
// Top of the frame receiver testbench: clock, reset, register settings and byte stimulus.
// Prediction and comparison live in frame_checker. Depends on gbfr_pkg and the RTL top.
module tb;
	import gbfr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [7:0]         cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall;
	logic               end_of_frame;
	logic [7:0]         message_id;
	logic [7:0]         byte_value;
	logic [15:0]        byte_index;
	logic [15:0]        frame_length;
	logic               frame_ok;
	int unsigned        fail_count;
	int unsigned        items_due;

	logic [7:0] cur_sync1, cur_sync2, cur_class;
	logic [7:0] tx_sum_a, tx_sum_b;
	bit         idle_on;
	int         frame_bytes, frames_sent, spoiled_frames;

	gnss_binary_frame_receiver u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.end_of_frame(end_of_frame), .message_id(message_id), .byte_value(byte_value),
		.byte_index(byte_index), .frame_length(frame_length), .frame_ok(frame_ok)
	);

	frame_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.end_of_frame(end_of_frame), .message_id(message_id), .byte_value(byte_value),
		.byte_index(byte_index), .frame_length(frame_length), .frame_ok(frame_ok),
		.fail_count(fail_count), .items_due(items_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	// The output side stalls in random bursts whenever idling is enabled.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_rx(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_summed(input logic [7:0] b);
		tx_sum_a = tx_sum_a + b;
		tx_sum_b = tx_sum_b + tx_sum_a;
		send_rx(b);
	endtask

	// spoil bit 0 corrupts the first checksum byte, bit 1 the second.
	task automatic send_frame(input logic [7:0] id, input logic [15:0] len,
			input logic [1:0] spoil);
		logic [7:0] pb;
		tx_sum_a = 8'h00;
		tx_sum_b = 8'h00;
		send_rx(cur_sync1);
		send_rx(cur_sync2);
		send_summed(cur_class);
		send_summed(id);
		send_summed(len[7:0]);
		send_summed(len[15:8]);
		for (int i = 0; i < int'(len); i++) begin
			if ($urandom_range(0, 9) == 0) pb = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			else pb = 8'($urandom);
			send_summed(pb);
		end
		send_rx(spoil[0] ? ~tx_sum_a : tx_sum_a);
		send_rx(spoil[1] ? tx_sum_b + 8'd1 : tx_sum_b);
		frame_bytes += 8 + int'(len);
		frames_sent++;
		if (spoil != 2'b00) spoiled_frames++;
	endtask

	// Registers change only once the receiver has drained and settled.
	task automatic set_regs(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] cls);
		in_valid <= 1'b0;
		while (items_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SYNC_FIRST;
		cfg_wdata <= s1;
		@(negedge clk);
		cfg_idx <= REG_SYNC_SECOND;
		cfg_wdata <= s2;
		@(negedge clk);
		cfg_idx <= REG_CLASS_ACCEPT;
		cfg_wdata <= cls;
		@(negedge clk);
		cfg_idx <= REG_SPARE;
		cfg_wdata <= 8'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_sync1 = s1;
		cur_sync2 = s2;
		cur_class = cls;
	endtask

	// Every chunk starts and ends with the receiver hunting for the first sync byte.
	task automatic run_random(input int target);
		int start, pick, n;
		logic [7:0] nb;
		logic [1:0] spoil;
		logic [15:0] len;
		start = frame_bytes;
		while (frame_bytes - start < target) begin
			idle_on = ($urandom_range(0, 5) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = $urandom_range(0, 19);
				if (n == 0) len = 16'd0;
				else if (n < 17) len = 16'($urandom_range(1, 12));
				else len = 16'($urandom_range(13, 48));
				spoil = ($urandom_range(0, 6) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
				send_frame(8'($urandom), len, spoil);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 6)) begin
					do nb = 8'($urandom); while (nb == cur_sync1);
					send_rx(nb);
				end
			end else if (pick < 90) begin
				send_rx(cur_sync1);
				do nb = 8'($urandom); while (nb == cur_sync2);
				send_rx(nb);
			end else begin
				send_rx(cur_sync1);
				send_rx(cur_sync2);
				do nb = 8'($urandom); while (nb == cur_class);
				send_rx(nb);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_SYNC_FIRST;
		cfg_wdata = 8'h00;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		idle_on = 1'b1;
		frame_bytes = 0;
		frames_sent = 0;
		spoiled_frames = 0;
		cur_sync1 = SYNC_FIRST_RST;
		cur_sync2 = SYNC_SECOND_RST;
		cur_class = CLASS_ACCEPT_RST;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty frame, bad checksum, wrong second sync, repeated first sync,
		// wrong class, all with the reset register values.
		send_frame(8'hFF, 16'd0, 2'b00);
		send_frame(8'h00, 16'd1, 2'b11);
		send_rx(cur_sync1);
		send_rx(8'h00);
		send_rx(cur_sync1);
		send_rx(cur_sync1);
		send_rx(cur_sync1);
		send_rx(cur_sync2);
		send_rx(8'h07);

		run_random(150);
		set_regs(8'h00, 8'hFF, 8'h00);
		run_random(150);
		set_regs(8'hFF, 8'h00, 8'hFF);
		run_random(150);
		set_regs(8'h55, 8'h55, 8'($urandom));
		run_random(150);

		// Closing part without idling: a frame longer than 255 bytes and a few short ones.
		idle_on = 1'b0;
		set_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, CLASS_ACCEPT_RST);
		send_frame(8'($urandom), 16'd260, 2'b00);
		send_frame(8'($urandom), 16'd3, 2'b10);
		send_frame(8'($urandom), 16'd0, 2'b01);
		in_valid <= 1'b0;
		while (items_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d frames (%0d with a corrupted checksum), %0d frame bytes in all,",
			frames_sent, spoiled_frames, frame_bytes);
		$display("plus sync and class errors and noise, over five register settings.");
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
